// ----- rtl/core/eqh_pkg.sv -----
// shared constants and types of the equal-width range histogram
package eqh_pkg;

  // default sizes
  localparam int NUM_BINS_DEF    = 15;
  localparam int MAX_SAMPLES_DEF = 1024;

  // field widths
  localparam int DELAY_W     = 16;
  localparam int INDEX_W     = 4;
  localparam int HITS_W      = 11;
  localparam int SHARE_W     = 17;
  localparam int SHARE_FRAC  = 16;
  localparam int MID_W       = 22;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  // two sample banks, so two sets can be in flight
  localparam int JOBQ_DEPTH = 2;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  // back end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN_RD,
    BK_SCAN_START,
    BK_SCAN_DIV,
    BK_CNT_WR,
    BK_EMIT_RD,
    BK_EMIT_START,
    BK_EMIT_DIV,
    BK_EMIT_OUT
  } back_state_t;

endpackage

// ----- rtl/core/eqh_front.sv -----
// front end: takes samples, writes the sample bank, tracks min, max and count
module eqh_front
  import eqh_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int IW = $clog2(MAX_SAMPLES),
  localparam int JOB_W = 1 + CW + 2 * DELAY_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // delay_ms
  input  logic                  in_tlast,   // last_sample
  input  logic                  job_full,
  output logic                  job_push,
  output logic [JOB_W-1:0]      job_data,
  output logic                  smp_wr_en,
  output logic [IW:0]           smp_wr_addr,
  output logic [DELAY_W-1:0]    smp_wr_data
);

  typedef struct packed {
    logic               bank;
    logic [CW-1:0]      total;
    logic [DELAY_W-1:0] min_val;
    logic [DELAY_W-1:0] range_val;
  } job_t;

  job_t               job;
  logic               bank_r, bank_nxt;
  logic [CW-1:0]      total_r, total_nxt, total_upd;
  logic [DELAY_W-1:0] min_r, min_nxt, min_upd;
  logic [DELAY_W-1:0] max_r, max_nxt, max_upd;
  logic [DELAY_W-1:0] smp;
  logic               accept;
  logic               store;

  // a bank is free whenever the job queue has room
  assign in_tready = !job_full;
  assign accept    = in_tvalid && in_tready;
  assign smp       = in_tdata[DELAY_W-1:0];
  assign store     = accept && (total_r < CW'(MAX_SAMPLES));

  // sample bank write
  assign smp_wr_en   = store;
  assign smp_wr_addr = {bank_r, total_r[IW-1:0]};
  assign smp_wr_data = smp;

  // running statistics including this request
  always_comb begin
    min_upd   = (store && (smp < min_r)) ? smp : min_r;
    max_upd   = (store && (smp > max_r)) ? smp : max_r;
    total_upd = store ? total_r + CW'(1) : total_r;
  end

  // job descriptor on the flagged sample
  always_comb begin
    job.bank      = bank_r;
    job.total     = total_upd;
    job.min_val   = min_upd;
    job.range_val = (max_upd >= min_upd) ? max_upd - min_upd : '0;
  end

  assign job_push = accept && in_tlast;
  assign job_data = job;

  // next set state
  always_comb begin
    if (job_push) begin
      total_nxt = '0;
      min_nxt   = DELAY_MAX;
      max_nxt   = '0;
      bank_nxt  = !bank_r;
    end else begin
      total_nxt = total_upd;
      min_nxt   = min_upd;
      max_nxt   = max_upd;
      bank_nxt  = bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      min_r   <= DELAY_MAX;
      max_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      total_r <= total_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// ----- rtl/core/eqh_jobq.sv -----
// two-entry queue of set descriptors between front and back end
module eqh_jobq
  import eqh_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int PW = $clog2(JOBQ_DEPTH);
  localparam int NW = $clog2(JOBQ_DEPTH + 1);

  logic [W-1:0]  entry_r [JOBQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign full       = (cnt_r == NW'(JOBQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_r + NW'(push) - NW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/core/eqh_div.sv -----
// shift-subtract divider, one quotient bit per cycle
module eqh_div #(
  parameter int NW = 27,
  parameter int DW = 16,
  parameter int QW = 17,
  localparam int SW = $clog2(QW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] steps,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsh_r, dsh_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          ge;

  assign ge   = (rem_r >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  // load aligns the divisor to the top quotient bit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = steps;
      rem_nxt  = W'(num);
      dsh_nxt  = W'(den) << (steps - SW'(1));
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      quo_nxt  = {quo_r[QW-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// ----- rtl/core/eqh_back.sv -----
// back end: sample banks, binning pass, bin counters and result output
module eqh_back
  import eqh_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int IW = $clog2(MAX_SAMPLES),
  localparam int JOB_W = 1 + CW + 2 * DELAY_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  logic [JOB_W-1:0]       job_data,
  output logic                   job_pop,
  input  logic                   smp_wr_en,
  input  logic [IW:0]            smp_wr_addr,
  input  logic [DELAY_W-1:0]     smp_wr_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // bin_index, bin_hits, hit_share, midpoint_x30
  output logic                   out_tlast   // final_bin
);

  localparam int BIW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int BQW    = $clog2(NUM_BINS + 1);
  localparam int SDEPTH = 2 ** (IW + 1);
  localparam int DNW    = (DELAY_W + BQW > CW + SHARE_FRAC) ? DELAY_W + BQW : CW + SHARE_FRAC;
  localparam int DDW    = (DELAY_W > CW) ? DELAY_W : CW;
  localparam int DSW    = $clog2(SHARE_W + 1);
  localparam int PAD_W  = OUT_TDATA_W - INDEX_W - HITS_W - SHARE_W - MID_W;

  typedef struct packed {
    logic               bank;
    logic [CW-1:0]      total;
    logic [DELAY_W-1:0] min_val;
    logic [DELAY_W-1:0] range_val;
  } job_t;

  job_t head;

  // sequencer registers
  back_state_t        state_r, state_nxt;
  logic               bank_r, bank_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [DELAY_W-1:0] min_r, min_nxt;
  logic [DELAY_W-1:0] range_r, range_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [BIW-1:0]     i_r, i_nxt;
  logic [MID_W-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]      hits_r, hits_nxt;
  logic               advance;
  logic               scan_last;

  // memories
  logic [DELAY_W-1:0] smp_mem [SDEPTH];
  logic [DELAY_W-1:0] smp_rd_r;
  logic [CW-1:0]      cnt_mem [NUM_BINS];
  logic [NUM_BINS-1:0] cnt_vld_r;
  logic [CW-1:0]      cnt_rd_r;
  logic               cnt_vld_rd_r;
  logic [BIW-1:0]     cnt_raddr;
  logic [BIW-1:0]     cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic               cnt_we;
  logic               cnt_clr;

  // divider
  logic               div_start;
  logic [DNW-1:0]     div_num;
  logic [DDW-1:0]     div_den;
  logic [DSW-1:0]     div_steps;
  logic               div_done;
  logic [SHARE_W-1:0] div_quo;

  // output register
  logic               out_valid_r;
  logic               out_load;
  logic               out_free;
  logic [INDEX_W-1:0] out_index_r;
  logic [HITS_W-1:0]  out_hits_r;
  logic [SHARE_W-1:0] out_share_r;
  logic [MID_W-1:0]   out_mid_r;
  logic               out_last_r;

  assign head      = job_data;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_last = ((k_r + CW'(1)) == total_r);
  assign cnt_raddr = (state_r == BK_EMIT_RD) ? i_r : BIW'(div_quo);
  assign cnt_waddr = BIW'(div_quo);
  assign cnt_wdata = (cnt_vld_rd_r ? cnt_rd_r : '0) + CW'(1);

  eqh_div #(
    .NW(DNW),
    .DW(DDW),
    .QW(SHARE_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .steps(div_steps),
    .done (div_done),
    .quo  (div_quo)
  );

  // sequencer next state and controls
  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    total_nxt = total_r;
    min_nxt   = min_r;
    range_nxt = range_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    mid_nxt   = mid_r;
    hits_nxt  = hits_r;
    advance   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    cnt_we    = 1'b0;
    cnt_clr   = 1'b0;
    job_pop   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          bank_nxt  = head.bank;
          total_nxt = head.total;
          min_nxt   = head.min_val;
          range_nxt = head.range_val;
          k_nxt     = '0;
          i_nxt     = '0;
          mid_nxt   = MID_W'(head.min_val) * MID_W'(2 * NUM_BINS) + MID_W'(head.range_val);
          if ((head.range_val != '0) && (head.total != '0)) begin
            state_nxt = BK_SCAN_RD;
          end else begin
            state_nxt = BK_EMIT_RD;
          end
        end
      end
      BK_SCAN_RD: begin
        state_nxt = BK_SCAN_START;
      end
      // offset times bin count over range gives the bin
      BK_SCAN_START: begin
        if (smp_rd_r >= min_r) begin
          div_start = 1'b1;
          div_num   = DNW'(DELAY_W'(smp_rd_r - min_r)) * DNW'(NUM_BINS);
          div_den   = DDW'(range_r);
          div_steps = DSW'(BQW);
          state_nxt = BK_SCAN_DIV;
        end else begin
          advance = 1'b1;
        end
      end
      BK_SCAN_DIV: begin
        if (div_done) begin
          if (div_quo < SHARE_W'(NUM_BINS)) begin
            state_nxt = BK_CNT_WR;
          end else begin
            advance = 1'b1;
          end
        end
      end
      BK_CNT_WR: begin
        cnt_we  = 1'b1;
        advance = 1'b1;
      end
      BK_EMIT_RD: begin
        state_nxt = BK_EMIT_START;
      end
      // share is hits scaled by 2^16 over the total
      BK_EMIT_START: begin
        hits_nxt  = cnt_vld_rd_r ? cnt_rd_r : '0;
        div_start = 1'b1;
        div_num   = DNW'(hits_nxt) << SHARE_FRAC;
        div_den   = DDW'(total_r);
        div_steps = DSW'(SHARE_W);
        state_nxt = BK_EMIT_DIV;
      end
      BK_EMIT_DIV: begin
        if (div_done) state_nxt = BK_EMIT_OUT;
      end
      BK_EMIT_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          mid_nxt  = mid_r + MID_W'({range_r, 1'b0});
          if (i_r == BIW'(NUM_BINS - 1)) begin
            cnt_clr   = 1'b1;
            job_pop   = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            i_nxt     = i_r + BIW'(1);
            state_nxt = BK_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    // step to the next stored sample or on to the output pass
    if (advance) begin
      if (scan_last) begin
        i_nxt     = '0;
        state_nxt = BK_EMIT_RD;
      end else begin
        k_nxt     = k_r + CW'(1);
        state_nxt = BK_SCAN_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r  <= bank_nxt;
    total_r <= total_nxt;
    min_r   <= min_nxt;
    range_r <= range_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    mid_r   <= mid_nxt;
    hits_r  <= hits_nxt;
  end

  // sample banks, one write and one registered read
  always_ff @(posedge clk) begin
    if (smp_wr_en) smp_mem[smp_wr_addr] <= smp_wr_data;
    smp_rd_r <= smp_mem[{bank_r, k_r[IW-1:0]}];
  end

  // bin counters, registered read
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_r     <= cnt_mem[cnt_raddr];
    cnt_vld_rd_r <= cnt_vld_r[cnt_raddr];
  end

  // counter valid bits, cleared at reset and after each set
  always_ff @(posedge clk) begin
    if (!rst_n || cnt_clr) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[cnt_waddr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= INDEX_W'(i_r);
      out_hits_r  <= HITS_W'(hits_r);
      out_share_r <= (total_r == '0) ? '0 : div_quo;
      out_mid_r   <= mid_r;
      out_last_r  <= (i_r == BIW'(NUM_BINS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_mid_r, out_share_r, out_hits_r, out_index_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/equal_width_range_histogram.sv -----
// top level: equal-width range histogram over a loaded set of delay samples
// samples are taken one per cycle into one of two sample banks; a new set loads while
// the previous one is binned, and input stalls only while both banks hold pending sets
// binning pass: per sample, a sample bank read, a divide for a clog2(NUM_BINS+1)-bit bin
// index and a counter write; then per bin a counter read and a 17-bit share divide
// reset clears counters, min/max, job queue and bin valid bits; sample banks are not cleared
module equal_width_range_histogram
  import eqh_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // delay_ms
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // bin_index, bin_hits, hit_share, midpoint_x30
  output logic                   out_tlast   // final_bin
);

  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int IW    = $clog2(MAX_SAMPLES);
  localparam int JOB_W = 1 + CW + 2 * DELAY_W;

  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_head_valid;
  logic [JOB_W-1:0]   job_push_data;
  logic [JOB_W-1:0]   job_head_data;
  logic               smp_wr_en;
  logic [IW:0]        smp_wr_addr;
  logic [DELAY_W-1:0] smp_wr_data;

  eqh_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .job_full   (job_full),
    .job_push   (job_push),
    .job_data   (job_push_data),
    .smp_wr_en  (smp_wr_en),
    .smp_wr_addr(smp_wr_addr),
    .smp_wr_data(smp_wr_data)
  );

  eqh_jobq #(
    .W(JOB_W)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_push_data),
    .full      (job_full),
    .pop       (job_pop),
    .head_valid(job_head_valid),
    .head_data (job_head_data)
  );

  eqh_back #(
    .NUM_BINS   (NUM_BINS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_head_valid),
    .job_data   (job_head_data),
    .job_pop    (job_pop),
    .smp_wr_en  (smp_wr_en),
    .smp_wr_addr(smp_wr_addr),
    .smp_wr_data(smp_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // no set descriptor is pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
    else $error("set descriptor pushed into full queue");

  // a flagged sample leaves a pending set behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> job_head_valid)
    else $error("flagged sample did not queue a set");

  // a set is retired only together with its final bin result
  assert property (@(posedge clk) disable iff (!rst_n) job_pop |=> (out_tvalid && out_tlast))
    else $error("set retired without final bin result");

endmodule
